// ----- rtl/increasing_sequence_counter_top_defines.svh -----
// Assertion macros shared by the increasing sequence counter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef INCREASING_SEQUENCE_COUNTER_TOP_DEFINES_SVH
`define INCREASING_SEQUENCE_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/isc_pkg.sv -----
// Package for the increasing sequence counter: default sizes and request codes.
// Depends on nothing; used by increasing_sequence_counter_top.
package isc_pkg;

    // Default number of distinct values and internal count width.
    localparam int VALUE_RANGE_DEF = 1024;
    localparam int COUNT_WIDTH_DEF = 32;

    // Count ports carry the low 32 bits of the internal counts.
    localparam int OUT_COUNT_W = 32;

    // Request codes on req_type.
    typedef enum logic {
        REQ_CLEAR = 1'b0,
        REQ_ADD   = 1'b1
    } req_type_t;

endpackage

// ----- rtl/increasing_sequence_counter_top.sv -----
// Increasing sequence counter: longest strictly increasing chains with counts.
// Depends on isc_pkg and increasing_sequence_counter_top_defines.svh.
//
// Usage:
// Items enter on start/req_type/value and are taken at a rising edge where
// start is high and busy is low. An add item (req_type = REQ_ADD) folds its
// value into a max-with-count segment tree kept in one synchronous memory of
// 2 * 2^ceil(log2(VALUE_RANGE)) entries, indexed by value. A clear item
// zeroes the whole tree. Every item yields exactly one result, shown for one
// cycle with done high; the receiver cannot stall, so it must take it then.
// The user writes the target_length register via cfg_we/cfg_wdata only while idle; unchecked.
//
// Sequencing, with LEVELS = ceil(log2(VALUE_RANGE)) (10 by default):
// An add item with an in-range value walks the tree twice through the single
// memory read port: LEVELS reads for the prefix query, then LEVELS + 1
// read-modify-write steps from leaf to root. done rises as the root
// write-back lands and busy falls in that same cycle, so a new item is taken
// only once the current one is done. An out-of-range value only reads the
// root: done rises in the cycle after acceptance, with busy falling in that
// same cycle. A clear item shows its all-zero result on the next cycle and
// then keeps busy high for the clearing pass over all 2 * 2^LEVELS entries.
// After reset the same clearing pass runs with busy high before the first
// item is taken.

`include "increasing_sequence_counter_top_defines.svh"

module increasing_sequence_counter_top #(
    parameter int VALUE_RANGE = isc_pkg::VALUE_RANGE_DEF,
    parameter int COUNT_WIDTH = isc_pkg::COUNT_WIDTH_DEF,
    localparam int LEN_W = $clog2(VALUE_RANGE + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [LEN_W-1:0]                cfg_wdata,
    input  logic                            start,
    output logic                            busy,
    input  logic                            req_type,
    input  logic [LEN_W-1:0]                value,
    output logic                            done,
    output logic [LEN_W-1:0]                end_length,
    output logic [isc_pkg::OUT_COUNT_W-1:0] end_count,
    output logic [LEN_W-1:0]                best_length,
    output logic [isc_pkg::OUT_COUNT_W-1:0] best_count,
    output logic [isc_pkg::OUT_COUNT_W-1:0] target_count
);

    // Tree geometry: leaves 2^LEVELS .. 2^(LEVELS+1)-1, root at address 1.
    localparam int LEVELS   = $clog2(VALUE_RANGE);
    localparam int N_LEAVES = 1 << LEVELS;
    localparam int ADDR_W   = LEVELS + 1;
    localparam int DEPTH    = 2 * N_LEAVES;
    localparam int LVL_W    = $clog2(LEVELS + 1);
    localparam logic [ADDR_W-1:0] ROOT_ADDR = ADDR_W'(1);

    typedef struct packed {
        logic [LEN_W-1:0]       len;
        logic [COUNT_WIDTH-1:0] cnt;
    } node_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_QUERY,
        ST_UPDATE,
        ST_WAIT
    } state_t;

    // What the read issued last cycle was for.
    typedef enum logic [1:0] {
        DK_NONE,
        DK_QRY,
        DK_UPD,
        DK_ROOT
    } data_kind_t;

    // Saturating add of two counts.
    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [COUNT_WIDTH-1:0] b
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    // Max-with-count merge: a longer length wins, an equal one adds counts.
    function automatic node_t merge(input node_t a, input node_t b);
        node_t r;
        r = a;
        if (b.len > a.len)
        begin
            r = b;
        end
        else if (b.len == a.len)
        begin
            r.cnt = sat_add(a.cnt, b.cnt);
        end
        return r;
    endfunction

    // Low 32 bits of a count, zero extended when the count is narrower.
    function automatic logic [isc_pkg::OUT_COUNT_W-1:0] to_out(
        input logic [COUNT_WIDTH-1:0] c
    );
        logic [63:0] w;
        w = 64'(c);
        return w[isc_pkg::OUT_COUNT_W-1:0];
    endfunction

    // Tree memory, one read port with registered data and one write port.
    node_t mem [DEPTH];
    node_t rd_data_reg;

    state_t             state_reg;
    data_kind_t         d_kind_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic [ADDR_W-1:0]  leaf_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [ADDR_W-1:0]  d_addr_reg;
    logic               d_use_reg;
    logic               d_last_reg;
    node_t              acc_reg;
    logic [LEN_W-1:0]   target_reg;
    logic               done_reg;
    logic [LEN_W-1:0]   end_length_reg;
    logic [isc_pkg::OUT_COUNT_W-1:0] end_count_reg;
    logic [LEN_W-1:0]   best_length_reg;
    logic [isc_pkg::OUT_COUNT_W-1:0] best_count_reg;
    logic [isc_pkg::OUT_COUNT_W-1:0] target_count_reg;

    logic               accept;
    logic               in_range;
    logic [ADDR_W-1:0]  leaf_in;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    data_kind_t         iss_kind;
    logic               iss_use;
    logic               iss_last;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    node_t              wr_data;
    node_t              ins_node;
    node_t              upd_node;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (value != '0) && (value <= LEN_W'(VALUE_RANGE));
    assign leaf_in  = ADDR_W'(N_LEAVES) + ADDR_W'(value) - ADDR_W'(1);

    // The chain to insert: prefix best plus one; an empty prefix is one chain.
    always_comb
    begin
        ins_node.len = acc_reg.len + LEN_W'(1);
        ins_node.cnt = (acc_reg.len == '0) ? COUNT_WIDTH'(1) : acc_reg.cnt;
    end

    // Merging the new chain straight into every node on the leaf-to-root path
    // matches recomputing each node from its children, since a replaced leaf
    // pair was never longer than the new one.
    assign upd_node = merge(rd_data_reg, ins_node);

    // Read issue. The query reads the left sibling at each level where the
    // path node is a right child; the update reads the path nodes themselves.
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = pos_reg;
        iss_kind = DK_NONE;
        iss_use  = 1'b0;
        iss_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == isc_pkg::REQ_ADD) && !in_range)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ROOT_ADDR;
                    iss_kind = DK_ROOT;
                end
            end
            ST_QUERY:
            begin
                rd_en    = 1'b1;
                rd_addr  = pos_reg ^ ADDR_W'(1);
                iss_kind = DK_QRY;
                iss_use  = pos_reg[0];
            end
            ST_UPDATE:
            begin
                rd_en    = 1'b1;
                iss_kind = DK_UPD;
                iss_last = (lvl_reg == LVL_W'(LEVELS));
            end
            default:
            begin
            end
        endcase
    end

    // Writes come from the clearing pass or from the update write-back, which
    // lands in the cycle after its read, always on a different node than the
    // read of that cycle.
    always_comb
    begin
        wr_en   = (state_reg == ST_SWEEP) || (d_kind_reg == DK_UPD);
        wr_addr = (state_reg == ST_SWEEP) ? pos_reg : d_addr_reg;
        wr_data = (state_reg == ST_SWEEP) ? '0 : upd_node;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            pos_reg    <= '0;
            lvl_reg    <= '0;
            d_kind_reg <= DK_NONE;
            done_reg   <= 1'b0;
            target_reg <= '0;
        end
        else
        begin
            done_reg   <= 1'b0;
            d_kind_reg <= iss_kind;
            d_addr_reg <= rd_addr;
            d_use_reg  <= iss_use;
            d_last_reg <= iss_last;

            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type == isc_pkg::REQ_CLEAR)
                        begin
                            // The result of a clear is all zero; the sweep follows.
                            state_reg        <= ST_SWEEP;
                            pos_reg          <= '0;
                            done_reg         <= 1'b1;
                            end_length_reg   <= '0;
                            end_count_reg    <= '0;
                            best_length_reg  <= '0;
                            best_count_reg   <= '0;
                            target_count_reg <= '0;
                        end
                        else if (in_range)
                        begin
                            state_reg <= ST_QUERY;
                            pos_reg   <= leaf_in;
                            leaf_reg  <= leaf_in;
                            lvl_reg   <= '0;
                            acc_reg   <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    pos_reg <= pos_reg + ADDR_W'(1);
                    if (pos_reg == {ADDR_W{1'b1}})
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_QUERY:
                begin
                    pos_reg <= pos_reg >> 1;
                    lvl_reg <= lvl_reg + LVL_W'(1);
                    if (lvl_reg == LVL_W'(LEVELS - 1))
                    begin
                        state_reg <= ST_UPDATE;
                        pos_reg   <= leaf_reg;
                        lvl_reg   <= '0;
                    end
                end
                ST_UPDATE:
                begin
                    pos_reg <= pos_reg >> 1;
                    lvl_reg <= lvl_reg + LVL_W'(1);
                    if (lvl_reg == LVL_W'(LEVELS))
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Returning read data.
            if ((d_kind_reg == DK_QRY) && d_use_reg)
            begin
                acc_reg <= merge(acc_reg, rd_data_reg);
            end

            if ((d_kind_reg == DK_UPD) && d_last_reg)
            begin
                // The root after its write-back is the best over all values.
                state_reg        <= ST_IDLE;
                done_reg         <= 1'b1;
                end_length_reg   <= ins_node.len;
                end_count_reg    <= to_out(ins_node.cnt);
                best_length_reg  <= upd_node.len;
                best_count_reg   <= to_out(upd_node.cnt);
                target_count_reg <= (upd_node.len == target_reg) ?
                                    to_out(upd_node.cnt) : '0;
            end

            if (d_kind_reg == DK_ROOT)
            begin
                state_reg        <= ST_IDLE;
                done_reg         <= 1'b1;
                end_length_reg   <= '0;
                end_count_reg    <= '0;
                best_length_reg  <= rd_data_reg.len;
                best_count_reg   <= to_out(rd_data_reg.cnt);
                target_count_reg <= (rd_data_reg.len == target_reg) ?
                                    to_out(rd_data_reg.cnt) : '0;
            end
        end
    end

    assign done         = done_reg;
    assign end_length   = end_length_reg;
    assign end_count    = end_count_reg;
    assign best_length  = best_length_reg;
    assign best_count   = best_count_reg;
    assign target_count = target_count_reg;

    // Memory writes only happen while the block is busy.
    `ISC_ASSERT_NOW(a_no_write_idle, clk, rst_n, wr_en,
                    state_reg != ST_IDLE, "memory write while idle")
    // A read never targets the node being written in the same cycle.
    `ISC_ASSERT_NOW(a_no_rw_collide, clk, rst_n, rd_en && wr_en,
                    rd_addr != wr_addr, "read and write hit the same node")
    // The root write-back is followed by the result strobe.
    `ISC_ASSERT_NEXT(a_root_done, clk, rst_n, (d_kind_reg == DK_UPD) && d_last_reg,
                     done_reg, "no result after root update")
    // The best chain is never shorter than the chain just ended.
    `ISC_ASSERT_NOW(a_best_ge_end, clk, rst_n, done_reg,
                    best_length_reg >= end_length_reg, "best length below end length")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for increasing_sequence_counter_top: a directed table, then random
// chain-building traffic, all scored against an in-bench chain-count predictor.
// Depends on isc_pkg and the RTL of increasing_sequence_counter_top.
module tb_top;

    // Sizes follow the block's defaults; the length ports are LEN_W bits wide.
    localparam int VR = isc_pkg::VALUE_RANGE_DEF;
    localparam int LEN_W = $clog2(VR + 1);
    localparam int CNT_W = isc_pkg::OUT_COUNT_W;
    // Settle time at the end, about as long as one full add walk.
    localparam int LATENCY = 2 * $clog2(VR) + 3;
    // Number of in-range add items after the directed table that the run aims for.
    localparam int RANDOM_ADDS = 1700;

    typedef logic [LEN_W-1:0] len_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One result item, in port order.
    typedef struct packed {
        len_t end_length;
        cnt_t end_count;
        len_t best_length;
        cnt_t best_count;
        cnt_t target_count;
    } chain_result_t;

    // Kinds of rows in the directed table: an item whose result is typed in, an item
    // scored by the predictor, or a write of the target_length register.
    typedef enum logic [1:0] {
        ROW_TYPED,
        ROW_PREDICTED,
        ROW_TARGET
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        isc_pkg::req_type_t req;
        len_t               v;
        chain_result_t      want;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    len_t cfg_wdata;
    logic start;
    logic busy;
    logic req_type;
    len_t value;
    logic done;
    len_t end_length;
    cnt_t end_count;
    len_t best_length;
    cnt_t best_count;
    cnt_t target_count;

    increasing_sequence_counter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .value        (value),
        .done         (done),
        .end_length   (end_length),
        .end_count    (end_count),
        .best_length  (best_length),
        .best_count   (best_count),
        .target_count (target_count)
    );

    // Predictor state: for every value, the longest chain ending there and how many such
    // chains exist, plus our copy of the target_length register.
    len_t chain_len [1:VR];
    cnt_t chain_cnt [1:VR];
    len_t target_len_q;

    // Results still owed by the block, oldest first.
    chain_result_t expected_chains[$];
    directed_row_t directed_rows[$];

    int mismatches;
    int adds_done;
    bit sender_quiet;

    // Free-running clock, 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("[increasing_sequence_counter_top] ERROR");
        $finish;
    end

    // Count addition that sticks at the all-ones value instead of wrapping.
    function automatic cnt_t sat_add_cnt(input cnt_t a, input cnt_t b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    endfunction

    // Longest chain length over values 1..hi and the total count of chains at that length.
    // Max and saturating sum commute, so a flat scan matches whatever tree the block uses.
    function automatic void scan_chains(input int hi, output len_t top_len,
                                        output cnt_t top_cnt);
        top_len = '0;
        top_cnt = '0;
        for (int i = 1; i <= hi && i <= VR; i++)
        begin
            if (chain_len[i] > top_len)
            begin
                top_len = chain_len[i];
                top_cnt = chain_cnt[i];
            end
            else if (chain_len[i] == top_len)
            begin
                top_cnt = sat_add_cnt(top_cnt, chain_cnt[i]);
            end
        end
    endfunction

    // Applies one item to the predictor state and returns the result it should produce.
    function automatic chain_result_t predict_chain(input isc_pkg::req_type_t req,
                                                    input len_t v);
        chain_result_t r;
        len_t prev_len;
        cnt_t prev_cnt;
        len_t new_len;
        len_t top_len;
        cnt_t top_cnt;
        int idx;
        r = '0;
        if (req == isc_pkg::REQ_CLEAR)
        begin
            for (int i = 1; i <= VR; i++)
            begin
                chain_len[i] = '0;
                chain_cnt[i] = '0;
            end
            return r;
        end
        idx = int'(v);
        if (idx >= 1 && idx <= VR)
        begin
            scan_chains(idx - 1, prev_len, prev_cnt);
            // Nothing below this value: the element starts a chain on its own.
            if (prev_len == '0)
                prev_cnt = 1;
            new_len = prev_len + 1'b1;
            if (chain_len[idx] == new_len)
            begin
                chain_cnt[idx] = sat_add_cnt(chain_cnt[idx], prev_cnt);
            end
            else if (chain_len[idx] < new_len)
            begin
                chain_len[idx] = new_len;
                chain_cnt[idx] = prev_cnt;
            end
            r.end_length = new_len;
            r.end_count  = prev_cnt;
        end
        // Out-of-range values leave the state alone and report only the running best.
        scan_chains(VR, top_len, top_cnt);
        r.best_length  = top_len;
        r.best_count   = top_cnt;
        r.target_count = (top_len == target_len_q) ? top_cnt : '0;
        return r;
    endfunction

    function automatic len_t current_best_len();
        len_t top_len;
        cnt_t top_cnt;
        scan_chains(VR, top_len, top_cnt);
        return top_len;
    endfunction

    function automatic chain_result_t mk_result(input int el, input longint ec, input int bl,
                                                input longint bc, input longint tc);
        chain_result_t r;
        r.end_length   = len_t'(el);
        r.end_count    = cnt_t'(ec);
        r.best_length  = len_t'(bl);
        r.best_count   = cnt_t'(bc);
        r.target_count = cnt_t'(tc);
        return r;
    endfunction

    function automatic void add_row(input row_kind_t kind, input isc_pkg::req_type_t req,
                                    input int v, input chain_result_t want);
        directed_row_t row;
        row.kind = kind;
        row.req  = req;
        row.v    = len_t'(v);
        row.want = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void check_field(input string name, input cnt_t want, input cnt_t got);
        if (want !== got)
        begin
            $error("%s: expected %0d (0x%0h), got %0d (0x%0h)", name, want, want, got, got);
            mismatches++;
        end
    endfunction

    // Result scoreboard. The block cannot be stalled, so every done pulse is one result
    // item, and it must match the oldest prediction field by field.
    always @(posedge clk)
    begin : result_check
        chain_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_chains.size() == 0)
            begin
                $error("result item with no item pending: end_length %0d best_length %0d",
                       end_length, best_length);
                mismatches++;
            end
            else
            begin
                want = expected_chains.pop_front();
                check_field("end_length", cnt_t'(want.end_length), cnt_t'(end_length));
                check_field("end_count", want.end_count, end_count);
                check_field("best_length", cnt_t'(want.best_length), cnt_t'(best_length));
                check_field("best_count", want.best_count, best_count);
                check_field("target_count", want.target_count, target_count);
            end
        end
    end

    // Gap before the next item; quiet stretches send back to back.
    function automatic int next_gap();
        return sender_quiet ? 0 : $urandom_range(9);
    endfunction

    // Presents one item and holds it until the block takes it. Called right after a rising
    // edge and returns right after the edge that accepted the item (plus any gap). With a
    // zero gap start stays high, so the next call raises no second assignment in the step.
    task automatic send_item(input isc_pkg::req_type_t req, input len_t v, input bit typed,
                             input chain_result_t want);
        chain_result_t predicted;
        int gap;
        start    <= 1'b1;
        req_type <= req;
        value    <= v;
        do @(posedge clk); while (busy !== 1'b0);
        predicted = predict_chain(req, v);
        expected_chains.insert(expected_chains.size(), typed ? want : predicted);
        if (req == isc_pkg::REQ_ADD && int'(v) >= 1 && int'(v) <= VR)
            adds_done++;
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic add_value(input int v);
        send_item(isc_pkg::REQ_ADD, len_t'(v), 1'b0, '0);
    endtask

    task automatic clear_chains();
        send_item(isc_pkg::REQ_CLEAR, len_t'($urandom_range(2047)), 1'b0, '0);
    endtask

    // Stops sending and waits until every owed result has arrived and busy is low. The
    // check runs on the falling edge, clear of the scoreboard's rising-edge update; it
    // returns right after a rising edge so the caller can drive at once.
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge clk); while (expected_chains.size() != 0 || busy !== 1'b0);
        @(posedge clk);
    endtask

    // target_length is only ever written with the block idle.
    task automatic write_target(input len_t t);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(posedge clk);
        cfg_we       <= 1'b0;
        target_len_q = t;
    endtask

    // Each value repeated three times over 22 consecutive values gives 3^22 chains,
    // well past the 32-bit limit, so node counts and best counts saturate.
    task automatic saturating_burst(input int base);
        for (int i = 0; i < 22; i++)
            repeat (3) add_value(base + i);
    endtask

    // One randomly chosen traffic pattern. Most patterns build real chains so that
    // lengths and counts grow; the rest is noise, clears, register writes and pauses.
    task automatic run_scenario();
        int pick;
        int n;
        int v;
        int base;
        pick = $urandom_range(99);
        sender_quiet = ($urandom_range(3) == 0);
        n = 0;
        if (pick < 35)
        begin
            // Mostly rising walk with the odd step back.
            n = $urandom_range(8, 40);
            v = $urandom_range(1, VR);
            repeat (n)
            begin
                v = v + $urandom_range(0, 3);
                if ($urandom_range(9) == 0)
                    v = v - $urandom_range(1, 20);
                if (v < 1)
                    v = 1;
                if (v > VR)
                    v = VR;
                add_value(v);
            end
        end
        else if (pick < 50)
        begin
            n = $urandom_range(5, 30);
            repeat (n) add_value($urandom_range(1, VR));
        end
        else if (pick < 65)
        begin
            // A narrow window of values: many equal lengths, so counts add up.
            n = $urandom_range(10, 40);
            base = ($urandom_range(1) == 0) ? 1 : $urandom_range(1, VR - 15);
            repeat (n) add_value(base + $urandom_range(15));
        end
        else if (pick < 75)
        begin
            // Out-of-range values mixed with valid ones.
            n = $urandom_range(3, 12);
            repeat (n)
            begin
                case ($urandom_range(2))
                    0: add_value(0);
                    1: add_value($urandom_range(VR + 1, 2047));
                    default: add_value($urandom_range(1, VR));
                endcase
            end
        end
        else if (pick < 80)
        begin
            // Falling run: every element starts a chain of its own.
            n = $urandom_range(5, 20);
            v = $urandom_range(n, VR);
            repeat (n)
            begin
                add_value(v);
                v = v - $urandom_range(1, v / n > 1 ? v / n : 1);
                if (v < 1)
                    v = 1;
            end
        end
        else if (pick < 84)
        begin
            clear_chains();
        end
        else if (pick < 88)
        begin
            if ($urandom_range(1) == 0)
                clear_chains();
            saturating_burst($urandom_range(1, VR - 21));
        end
        else if (pick < 95)
        begin
            // Half the time aim the target at the current best so target_count is live.
            if ($urandom_range(1) == 0)
            begin
                write_target(current_best_len());
            end
            else
            begin
                case ($urandom_range(4))
                    0: write_target('0);
                    1: write_target(len_t'(VR));
                    2: write_target('1);
                    3: write_target(len_t'($urandom_range(1, 40)));
                    default: write_target(len_t'($urandom_range(VR)));
                endcase
            end
        end
        else
        begin
            wait_drained();
        end
    endtask

    initial
    begin
        // Every input is known from time zero; reset is asserted from time zero.
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        start     <= 1'b0;
        req_type  <= isc_pkg::REQ_ADD;
        value     <= '0;
        mismatches   = 0;
        adds_done    = 0;
        sender_quiet = 1'b0;
        target_len_q = '0;
        for (int i = 1; i <= VR; i++)
        begin
            chain_len[i] = '0;
            chain_cnt[i] = '0;
        end

        // Directed table. Typed rows are ones whose result is obvious at a glance:
        // empty state, out-of-range values, clears and the first chains.
        add_row(ROW_TYPED, isc_pkg::REQ_ADD, 0, mk_result(0, 0, 0, 0, 0));
        add_row(ROW_TYPED, isc_pkg::REQ_ADD, 2047, mk_result(0, 0, 0, 0, 0));
        add_row(ROW_TYPED, isc_pkg::REQ_ADD, VR + 1, mk_result(0, 0, 0, 0, 0));
        add_row(ROW_TYPED, isc_pkg::REQ_ADD, VR, mk_result(1, 1, 1, 1, 0));
        add_row(ROW_TYPED, isc_pkg::REQ_ADD, 1, mk_result(1, 1, 1, 2, 0));
        add_row(ROW_TYPED, isc_pkg::REQ_ADD, 1, mk_result(1, 1, 1, 3, 0));
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, 2, '0);
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, VR, '0);
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, 0, '0);
        add_row(ROW_TARGET, isc_pkg::REQ_ADD, 3, '0);
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, 1365, '0);
        add_row(ROW_TYPED, isc_pkg::REQ_CLEAR, VR, mk_result(0, 0, 0, 0, 0));
        add_row(ROW_TYPED, isc_pkg::REQ_ADD, 0, mk_result(0, 0, 0, 0, 0));
        add_row(ROW_TARGET, isc_pkg::REQ_ADD, 1, '0);
        add_row(ROW_TYPED, isc_pkg::REQ_CLEAR, 2047, mk_result(0, 0, 0, 0, 0));
        add_row(ROW_TYPED, isc_pkg::REQ_ADD, 1, mk_result(1, 1, 1, 1, 1));
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, 682, '0);
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, 341, '0);
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, 1023, '0);
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, 1022, '0);
        add_row(ROW_TARGET, isc_pkg::REQ_ADD, 2047, '0);
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, VR, '0);
        add_row(ROW_PREDICTED, isc_pkg::REQ_ADD, VR, '0);
        add_row(ROW_TARGET, isc_pkg::REQ_ADD, 0, '0);
        add_row(ROW_TYPED, isc_pkg::REQ_CLEAR, 1, mk_result(0, 0, 0, 0, 0));
        add_row(ROW_TYPED, isc_pkg::REQ_ADD, 2, mk_result(1, 1, 1, 1, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block runs its clearing pass after reset; send_item simply waits on busy.
        foreach (directed_rows[i])
        begin
            sender_quiet = ($urandom_range(2) == 0);
            case (directed_rows[i].kind)
                ROW_TARGET: write_target(directed_rows[i].v);
                ROW_TYPED: send_item(directed_rows[i].req, directed_rows[i].v, 1'b1,
                                     directed_rows[i].want);
                default: send_item(directed_rows[i].req, directed_rows[i].v, 1'b0, '0);
            endcase
        end

        adds_done = 0;

        // Saturation from a clean state, then aim the target at the saturated best and
        // read it back through out-of-range items.
        sender_quiet = 1'b0;
        clear_chains();
        saturating_burst(1);
        write_target(current_best_len());
        add_value(0);
        add_value(VR + 1);
        add_value(2047);

        // The longest possible chain: every value once, in rising order.
        clear_chains();
        write_target(len_t'(VR));
        for (int v = 1; v <= VR; v++)
        begin
            if (v % 64 == 1)
                sender_quiet = ($urandom_range(2) == 0);
            add_value(v);
        end
        add_value(0);

        while (adds_done < RANDOM_ADDS)
            run_scenario();

        // Let the last results arrive, then give stray pulses a chance to show up.
        wait_drained();
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("[increasing_sequence_counter_top] OK");
        else
            $display("[increasing_sequence_counter_top] ERROR");
        $finish;
    end

endmodule
